/* sv/bsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, widths and codes of the bisection root-search block.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // word and counter widths (Q16.16 data, iteration counter)
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 16;
  localparam int RES_W   = WORD_W - 1;
  localparam int CFG_W   = RES_W;

  // opcodes of an input item
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic CFG_TOLERANCE  = 1'b0;
  localparam logic CFG_ITER_LIMIT = 1'b1;

  // configuration reset values
  localparam logic [RES_W-1:0]   TOL_RESET   = RES_W'(66);
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(100);

  // result status codes
  typedef enum logic [2:0] {
    ST_EVAL        = 3'd0,
    ST_CONVERGED   = 3'd1,
    ST_LIMIT       = 3'd2,
    ST_BAD_BRACKET = 3'd3,
    ST_BAD_CONFIG  = 3'd4,
    ST_IGNORED     = 3'd5
  } status_t;

  // input item as held in the input register
  typedef struct packed {
    logic                     opcode;
    logic signed [WORD_W-1:0] left_bound;
    logic signed [WORD_W-1:0] right_bound;
    logic signed [WORD_W-1:0] left_value;
    logic signed [WORD_W-1:0] right_value;
    logic signed [WORD_W-1:0] sample_value;
  } in_item_t;

  // floor((a + b) / 2) without overflow
  function automatic logic [WORD_W-1:0] midpoint(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] sum;
    begin
      sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      midpoint = sum[WORD_W:1];
    end
  endfunction

  // |a - b|, one bit wider than a word
  function automatic logic [WORD_W:0] span(input logic [WORD_W-1:0] a,
                                           input logic [WORD_W-1:0] b);
    logic [WORD_W:0] diff;
    begin
      diff = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      span = diff[WORD_W] ? (~diff + 1'b1) : diff;
    end
  endfunction

  // |v| saturated to the residual range
  function automatic logic [RES_W-1:0] abs_sat(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] mag;
    begin
      mag     = v[WORD_W-1] ? (~v + 1'b1) : v;
      abs_sat = mag[WORD_W-1] ? {RES_W{1'b1}} : mag[RES_W-1:0];
    end
  endfunction

endpackage

/* sv/bsr_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_in_if
// Input channel: start and sample items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsr_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic signed [bsr_pkg::WORD_W-1:0] left_bound;
  logic signed [bsr_pkg::WORD_W-1:0] right_bound;
  logic signed [bsr_pkg::WORD_W-1:0] left_value;
  logic signed [bsr_pkg::WORD_W-1:0] right_value;
  logic signed [bsr_pkg::WORD_W-1:0] sample_value;

  modport source (output valid, opcode, left_bound, right_bound, left_value,
                  right_value, sample_value, input ready);
  modport sink (input valid, opcode, left_bound, right_bound, left_value,
                right_value, sample_value, output ready);
endinterface

/* sv/bsr_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_out_if
// Result channel: status, point, residual and iteration count.
// ----------------------------------------------------------------------------
interface bsr_out_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic signed [bsr_pkg::WORD_W-1:0]  point;
  logic [bsr_pkg::RES_W-1:0]          residual;
  logic [bsr_pkg::COUNT_W-1:0]        iteration_count;

  modport source (output valid, status, point, residual, iteration_count,
                  input ready);
  modport sink (input valid, status, point, residual, iteration_count,
                output ready);
endinterface

/* sv/bisection_root_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisection_root_search
// Bisection root-search sequencer in Q16.16: checks a bracket, requests
// midpoint evaluations and halves the bracket on each sample item of a running search that does not converge.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      contents
//  in_ch     in         valid/ready    opcode, bounds, end values, sample
//  out_ch    out        valid/ready    status, point, residual, count
//  cfg_*     in         write enable   tolerance (0), iteration limit (1)
//
//  a result is offered once its item has sat in the input register and one
//  pass of add/shift/compare logic has loaded the result register
//  one item per cycle is sustained while out_ch takes each result; the
//  search state updates as the result register loads, so each item sees
//  the state left by the one before
//  reset (rst_n low, synchronous) empties both registers, idles the search
//  and restores the register defaults; a stalled output holds the input
//  register and then drops in_ch.ready
// ----------------------------------------------------------------------------
module bisection_root_search (
  input  logic                        clk,
  input  logic                        rst_n,
  bsr_in_if.sink                      in_ch,
  bsr_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0]   cfg_data
);

  localparam int W = bsr_pkg::WORD_W;
  localparam int C = bsr_pkg::COUNT_W;
  localparam int R = bsr_pkg::RES_W;

  // configuration
  logic [R-1:0]       tol_r;
  logic [C-1:0]       limit_r;

  // input register
  logic               s1_valid_r;
  bsr_pkg::in_item_t  s1_item_r;
  logic               s1_adv;

  // search state
  logic [W-1:0]       lower_r, lower_nxt;
  logic [W-1:0]       upper_r, upper_nxt;
  logic [W-1:0]       lower_val_r, lower_val_nxt;
  logic [W-1:0]       mid_r, mid_nxt;
  logic [C-1:0]       step_r, step_nxt;
  logic               active_r, active_nxt;

  // result register
  logic               out_valid_r;
  bsr_pkg::status_t   status_r, status_nxt;
  logic [W-1:0]       point_r, point_nxt;
  logic [R-1:0]       residual_r, residual_nxt;
  logic [C-1:0]       count_r, count_nxt;

  // sample evaluation terms
  logic [R-1:0]       res;
  logic [W:0]         width;
  logic               move_upper;
  logic [W-1:0]       new_lower, new_upper;

  // handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.point           = point_r;
  assign out_ch.residual        = residual_r;
  assign out_ch.iteration_count = count_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= bsr_pkg::TOL_RESET;
      limit_r <= bsr_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsr_pkg::CFG_TOLERANCE:  tol_r   <= cfg_data;
        bsr_pkg::CFG_ITER_LIMIT: limit_r <= cfg_data[C-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.opcode       <= in_ch.opcode;
      s1_item_r.left_bound   <= in_ch.left_bound;
      s1_item_r.right_bound  <= in_ch.right_bound;
      s1_item_r.left_value   <= in_ch.left_value;
      s1_item_r.right_value  <= in_ch.right_value;
      s1_item_r.sample_value <= in_ch.sample_value;
    end
  end

  // sample terms: residual, bracket width, which end moves
  assign res        = bsr_pkg::abs_sat(s1_item_r.sample_value);
  assign width      = bsr_pkg::span(upper_r, lower_r);
  assign move_upper = (s1_item_r.sample_value == '0) || (lower_val_r == '0) ||
                      (s1_item_r.sample_value[W-1] != lower_val_r[W-1]);
  assign new_lower  = move_upper ? lower_r : mid_r;
  assign new_upper  = move_upper ? mid_r : upper_r;

  // next search state and result
  always_comb begin
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    lower_val_nxt = lower_val_r;
    mid_nxt       = mid_r;
    step_nxt      = step_r;
    active_nxt    = active_r;
    status_nxt    = bsr_pkg::ST_IGNORED;
    point_nxt     = '0;
    residual_nxt  = '0;
    count_nxt     = '0;
    if (s1_item_r.opcode == bsr_pkg::OP_START) begin
      active_nxt = 1'b0;
      if (tol_r == '0 || limit_r == '0) begin
        status_nxt = bsr_pkg::ST_BAD_CONFIG;
      end else if (s1_item_r.left_value != '0 && s1_item_r.right_value != '0 &&
                   s1_item_r.left_value[W-1] == s1_item_r.right_value[W-1]) begin
        status_nxt = bsr_pkg::ST_BAD_BRACKET;
      end else begin
        lower_nxt     = s1_item_r.left_bound;
        upper_nxt     = s1_item_r.right_bound;
        lower_val_nxt = s1_item_r.left_value;
        step_nxt      = C'(1);
        mid_nxt       = bsr_pkg::midpoint(s1_item_r.left_bound,
                                          s1_item_r.right_bound);
        active_nxt    = 1'b1;
        status_nxt    = bsr_pkg::ST_EVAL;
        point_nxt     = mid_nxt;
        count_nxt     = C'(1);
      end
    end else if (active_r) begin
      residual_nxt = res;
      point_nxt    = mid_r;
      count_nxt    = step_r;
      if (res < tol_r || width < {2'b00, tol_r}) begin
        active_nxt = 1'b0;
        status_nxt = bsr_pkg::ST_CONVERGED;
      end else begin
        lower_nxt = new_lower;
        upper_nxt = new_upper;
        if (!move_upper) begin
          lower_val_nxt = s1_item_r.sample_value;
        end
        if (step_r >= limit_r) begin
          active_nxt = 1'b0;
          status_nxt = bsr_pkg::ST_LIMIT;
        end else begin
          step_nxt   = step_r + 1'b1;
          mid_nxt    = bsr_pkg::midpoint(new_lower, new_upper);
          status_nxt = bsr_pkg::ST_EVAL;
          point_nxt  = mid_nxt;
          count_nxt  = step_nxt;
        end
      end
    end
  end

  // search state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r     <= '0;
      upper_r     <= '0;
      lower_val_r <= '0;
      mid_r       <= '0;
      step_r      <= '0;
      active_r    <= 1'b0;
    end else if (s1_adv) begin
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      lower_val_r <= lower_val_nxt;
      mid_r       <= mid_nxt;
      step_r      <= step_nxt;
      active_r    <= active_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status_r   <= status_nxt;
      point_r    <= point_nxt;
      residual_r <= residual_nxt;
      count_r    <= count_nxt;
    end
  end

  // checks
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("item left the input register without a result");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(active_r) |-> out_valid_r && status_r == bsr_pkg::ST_EVAL &&
                        count_r == C'(1))
    else $error("search started without a first evaluation request");

  a_active_step: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> step_r != '0)
    else $error("active search with zero step number");

  a_eval_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == bsr_pkg::ST_EVAL |-> active_r &&
                                                   point_r == mid_r)
    else $error("evaluation request while search is idle");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == bsr_pkg::ST_BAD_CONFIG ||
                    status_r == bsr_pkg::ST_BAD_BRACKET) |-> !active_r &&
                    point_r == '0 && count_r == '0)
    else $error("rejected start left search running or fields set");

endmodule

/* tb/bsr_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_search_checker
// Watches the input, result and register ports of the bisection root-search
// block, keeps its own copy of the bracket and settings, works out the
// result of each accepted item and compares it with the result the block
// delivers, oldest first.
// ----------------------------------------------------------------------------
module bsr_search_checker
  import bsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  bsr_in_if                in_ch,
  bsr_out_if               out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               results_due
);

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  point;
    logic [RES_W-1:0]   residual;
    logic [COUNT_W-1:0] count;
  } search_result_t;

  // results still to come from the block, oldest at the front
  search_result_t due_q[$];

  // settings as last written
  logic [RES_W-1:0]   tol;
  logic [COUNT_W-1:0] lim;

  // bracket being searched
  logic [WORD_W-1:0]  lo_end;
  logic [WORD_W-1:0]  hi_end;
  logic [WORD_W-1:0]  lo_val;
  logic [WORD_W-1:0]  mid_pt;
  logic [COUNT_W-1:0] step;
  bit                 active;

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  // floor of the mean, taken in a wide signed sum
  function automatic logic [WORD_W-1:0] half_way(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    return WORD_W'(s >>> 1);
  endfunction

  // distance between the bracket ends, exact
  function automatic longint bracket_width(input logic [WORD_W-1:0] a,
                                           input logic [WORD_W-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? -d : d;
  endfunction

  // absolute sample value, clipped to the residual range
  function automatic longint clipped_magnitude(input logic [WORD_W-1:0] v);
    longint m;
    longint top;
    m   = longint'($signed(v));
    top = (longint'(1) << RES_W) - 1;
    if (m < 0) m = -m;
    return (m > top) ? top : m;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("%0t ns  mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // one item in, one expected result out
  task automatic predict_search(input logic op, input logic [WORD_W-1:0] lb,
                                input logic [WORD_W-1:0] rb,
                                input logic [WORD_W-1:0] lv,
                                input logic [WORD_W-1:0] rv,
                                input logic [WORD_W-1:0] sv);
    search_result_t r;
    longint res;
    longint wid;
    r.status   = ST_IGNORED;
    r.point    = '0;
    r.residual = '0;
    r.count    = '0;
    if (op == OP_START) begin
      active = 1'b0;
      if (tol == 0 || lim == 0) begin
        r.status = ST_BAD_CONFIG;
      end else if (lv != 0 && rv != 0 && lv[WORD_W-1] == rv[WORD_W-1]) begin
        r.status = ST_BAD_BRACKET;
      end else begin
        lo_end   = lb;
        hi_end   = rb;
        lo_val   = lv;
        step     = 1;
        mid_pt   = half_way(lb, rb);
        active   = 1'b1;
        r.status = ST_EVAL;
        r.point  = mid_pt;
        r.count  = step;
      end
    end else if (active) begin
      res        = clipped_magnitude(sv);
      wid        = bracket_width(hi_end, lo_end);
      r.point    = mid_pt;
      r.residual = RES_W'(res);
      r.count    = step;
      if (res < longint'(tol) || wid < longint'(tol)) begin
        active   = 1'b0;
        r.status = ST_CONVERGED;
      end else begin
        // keep the half across which the sign changes
        if (sv == 0 || lo_val == 0 || sv[WORD_W-1] != lo_val[WORD_W-1]) begin
          hi_end = mid_pt;
        end else begin
          lo_end = mid_pt;
          lo_val = sv;
        end
        if (step >= lim) begin
          active   = 1'b0;
          r.status = ST_LIMIT;
        end else begin
          step     = step + 1'b1;
          mid_pt   = half_way(lo_end, hi_end);
          r.status = ST_EVAL;
          r.point  = mid_pt;
          r.count  = step;
        end
      end
    end
    due_q.push_back(r);
  endtask

  // sample every port at the rising edge
  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      tol    = TOL_RESET;
      lim    = LIMIT_RESET;
      lo_end = '0;
      hi_end = '0;
      lo_val = '0;
      mid_pt = '0;
      step   = '0;
      active = 1'b0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TOLERANCE) tol = cfg_data[RES_W-1:0];
        else lim = cfg_data[COUNT_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_search(in_ch.opcode, in_ch.left_bound, in_ch.right_bound,
                       in_ch.left_value, in_ch.right_value, in_ch.sample_value);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("unexpected result status", out_ch.status, 0);
        end else begin
          want = due_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.point !== want.point)
            report_mismatch("point", out_ch.point, want.point);
          if (out_ch.residual !== want.residual)
            report_mismatch("residual", out_ch.residual, want.residual);
          if (out_ch.iteration_count !== want.count)
            report_mismatch("iteration count", out_ch.iteration_count, want.count);
        end
      end
    end
    results_due = due_q.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the bisection root-search block: a directed run over the bracket
// checks, sign cases, saturation and settings changed mid-search, then
// random searches under several settings with random stalls on both sides
// and two long hold-offs on the result side. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
  import bsr_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_FROM   = 1100;
  localparam int HOLD_AT_A    = 300;
  localparam int HOLD_AT_B    = 800;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 200000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               results_due;
  int unsigned      accepted = 0;
  int unsigned      cycles = 0;

  int                 planned;
  int                 phase_end;
  logic [RES_W-1:0]   tol_v;
  logic [COUNT_W-1:0] lim_v;
  logic [WORD_W-1:0]  lv;
  logic [WORD_W-1:0]  rv;

  bsr_in_if  in_ch ();
  bsr_out_if out_ch ();

  bisection_root_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bsr_search_checker search_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accepted items and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_ch.valid && in_ch.ready) accepted <= accepted + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL bisection_root_search");
      $finish;
    end
  end

  // result side: short random stalls, two long hold-offs, none near the end
  initial begin
    int hold_left;
    bit [1:0] holds_done;
    hold_left  = 0;
    holds_done = '0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!holds_done[0] && accepted >= HOLD_AT_A) begin
        holds_done[0] = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!holds_done[1] && accepted >= HOLD_AT_B) begin
        holds_done[1] = 1'b1;
        hold_left     = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (accepted < QUIET_FROM && $urandom_range(0, 4) == 0) begin
        hold_left     = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // random word with extremes, zero and small values mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(WORD_W-1){1'b0}}};
      1: return {1'b0, {(WORD_W-1){1'b1}}};
      2: return WORD_W'($urandom_range(0, 400)) - WORD_W'(200);
      3: return '0;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // offer one item, entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    if (accepted < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.opcode;
    in_ch.left_bound   <= it.left_bound;
    in_ch.right_bound  <= it.right_bound;
    in_ch.left_value   <= it.left_value;
    in_ch.right_value  <= it.right_value;
    in_ch.sample_value <= it.sample_value;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic start_search(input logic [WORD_W-1:0] lb, input logic [WORD_W-1:0] rb,
                              input logic [WORD_W-1:0] l_val,
                              input logic [WORD_W-1:0] r_val);
    in_item_t it;
    it.opcode       = OP_START;
    it.left_bound   = lb;
    it.right_bound  = rb;
    it.left_value   = l_val;
    it.right_value  = r_val;
    it.sample_value = WORD_W'($urandom);
    send_item(it);
  endtask

  task automatic give_sample(input logic [WORD_W-1:0] sv);
    in_item_t it;
    it.opcode       = OP_SAMPLE;
    it.left_bound   = WORD_W'($urandom);
    it.right_bound  = WORD_W'($urandom);
    it.left_value   = WORD_W'($urandom);
    it.right_value  = WORD_W'($urandom);
    it.sample_value = sv;
    send_item(it);
  endtask

  // let the block drain, then write one register
  task automatic write_setting(input logic idx, input logic [CFG_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_TOLERANCE;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_START;
    in_ch.left_bound   = '0;
    in_ch.right_bound  = '0;
    in_ch.left_value   = '0;
    in_ch.right_value  = '0;
    in_ch.sample_value = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sample with no search running
    give_sample(32'h8000_0000);
    // widest bracket, saturated residual, lower then upper end moves, zero sample
    start_search(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    give_sample(32'h8000_0000);
    give_sample(32'h7fff_ffff);
    give_sample(32'h0000_0000);
    give_sample(32'h0000_0005);
    // end values of one sign, both positive and both negative
    start_search(32'h0001_0000, 32'h0002_0000, 32'h0000_0001, 32'h7fff_ffff);
    start_search(32'h0001_0000, 32'h0002_0000, 32'hffff_ffff, 32'h8000_0000);
    // zero value at the left end, then a restart while searching
    start_search(32'hfff6_0000, 32'h000a_0000, 32'h0000_0000, 32'hffff_fffd);
    give_sample(32'hfff0_0000);
    start_search(32'h0000_0000, 32'h0000_0028, 32'hffff_0000, 32'h0000_0000);
    // bracket narrower than tolerance converges on width
    give_sample(32'h0100_0000);
    // both ends at the top, residual just under tolerance
    start_search(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    give_sample(32'h0000_0041);
    // residual equal to tolerance does not converge
    start_search(32'hff9c_0000, 32'h0064_0000, 32'hff9c_0000, 32'h0064_0000);
    give_sample(32'h0000_0042);
    give_sample(32'hffff_ffbe);

    // limit lowered while the search is running
    write_setting(CFG_ITER_LIMIT, CFG_W'(2));
    give_sample(32'h0010_0000);
    // tolerance cleared mid-search, limit still stops it
    write_setting(CFG_ITER_LIMIT, CFG_W'(100));
    start_search(32'hfff0_0000, 32'h0030_0000, 32'h0001_0000, 32'hffff_0000);
    write_setting(CFG_TOLERANCE, CFG_W'(0));
    write_setting(CFG_ITER_LIMIT, CFG_W'(3));
    give_sample(32'h0000_0000);
    give_sample(32'hffff_ffff);
    give_sample(32'h0000_0001);
    // zero settings refuse a start
    start_search(32'h0000_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    write_setting(CFG_TOLERANCE, CFG_W'(1));
    write_setting(CFG_ITER_LIMIT, CFG_W'(0));
    start_search(32'h0000_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    // largest settings
    write_setting(CFG_TOLERANCE, {1'b0, {(RES_W-1){1'b1}}} | CFG_W'(1) << (RES_W-1));
    write_setting(CFG_ITER_LIMIT, CFG_W'({COUNT_W{1'b1}}));
    start_search(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000);
    give_sample(32'h7fff_ffff);
    give_sample(32'hffff_fffb);

    // random searches under changing settings
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: tol_v = '0;
        1: tol_v = RES_W'(1);
        2: tol_v = TOL_RESET;
        3: tol_v = '1;
        4, 5: tol_v = RES_W'($urandom_range(1, 1 << 16));
        default: tol_v = RES_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: lim_v = '0;
        1: lim_v = COUNT_W'(1);
        2: lim_v = '1;
        3: lim_v = COUNT_W'($urandom);
        default: lim_v = COUNT_W'($urandom_range(2, 12));
      endcase
      write_setting(CFG_TOLERANCE, CFG_W'(tol_v));
      write_setting(CFG_ITER_LIMIT, CFG_W'(lim_v));
      phase_end = planned + ((tol_v == 0 || lim_v == 0) ? 15 : $urandom_range(120, 220));
      while (planned < phase_end && planned < RANDOM_ITEMS) begin
        lv = pick_word();
        rv = pick_word();
        // mostly a proper bracket, now and then one of a single sign
        if ($urandom_range(0, 7) != 0 && lv != 0 && rv != 0 &&
            lv[WORD_W-1] == rv[WORD_W-1]) rv = ~rv;
        start_search(pick_word(), pick_word(), lv, rv);
        planned++;
        repeat ($urandom_range(1, 16)) begin
          give_sample(pick_word());
          planned++;
        end
        // stray sample, usually after the search has ended
        if ($urandom_range(0, 9) == 0) give_sample(pick_word());
      end
    end

    // wait for the last results, then give the verdict
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("PASS bisection_root_search");
    else $display("FAIL bisection_root_search");
    $finish;
  end

endmodule

/* files.f */
sv/bsr_pkg.sv
sv/bsr_in_if.sv
sv/bsr_out_if.sv
sv/bisection_root_search.sv
tb/bsr_search_checker.sv
tb/tb.sv
